/* design/bba_pkg.sv */
// Shared types and constants for the bitmap block allocator.
// Depends on nothing; every other design file imports it.
package bba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_BITS  = 32;
    localparam int NWORDS     = MAX_BLOCKS / WORD_BITS;
    localparam int WADDR_W    = $clog2(NWORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int BLK_W      = WADDR_W + BIT_W;
    localparam int CNT_W      = 13;

    localparam logic [CNT_W-1:0]     MAX_CNT   = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0]     COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] TOP_BIT   = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WADDR_W-1:0]   LAST_WORD = WADDR_W'(NWORDS - 1);

    // Register indexes on the configuration port
    localparam logic CFG_TOTAL    = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_FORMAT = 2'd3
    } bba_op_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_NO_FREE      = 2'd1,
        STAT_RANGE        = 2'd2,
        STAT_ALREADY_FREE = 2'd3
    } bba_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIND,
        ST_ALLOC_END,
        ST_BIT_RD,
        ST_BIT_END,
        ST_FORMAT,
        ST_DONE
    } bba_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic rd_blk;
        logic find_load;
        logic alloc_commit;
        logic bit_commit;
        logic fmt_write;
        logic fmt_commit;
        logic out_load;
    } bba_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic free_zero;
        logic hit;
        logic last;
        logic fmt_last;
    } bba_stat_t;

endpackage

/* design/bba_ctrl.sv */
// Sequencer of the bitmap block allocator: input/output handshake and command steps.
// Depends on bba_pkg.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] command,
    input  logic       out_stall,
    input  bba_stat_t  stat,
    output logic       in_stall,
    output logic       out_valid,
    output bba_cmd_t   cmd
);

    bba_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    bba_op_t    op;

    assign op = bba_op_t'(command);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        CMD_ALLOC:  state_next = stat.free_zero ? ST_ALLOC_END : ST_SCAN;
                        CMD_FREE:   state_next = ST_BIT_RD;
                        CMD_TEST:   state_next = ST_BIT_RD;
                        CMD_FORMAT: state_next = ST_FORMAT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (stat.hit)
                    state_next = ST_FIND;
                else if (stat.last)
                    state_next = ST_ALLOC_END;
            end
            ST_FIND:      state_next = ST_ALLOC_END;
            ST_ALLOC_END: state_next = ST_DONE;
            ST_BIT_RD:    state_next = ST_BIT_END;
            ST_BIT_END:   state_next = ST_DONE;
            ST_FORMAT:
            begin
                if (stat.fmt_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SCAN:      cmd.rd_en = !stat.hit && !stat.last;
            ST_FIND:      cmd.find_load = 1'b1;
            ST_ALLOC_END: cmd.alloc_commit = 1'b1;
            ST_BIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_blk = 1'b1;
            end
            ST_BIT_END:   cmd.bit_commit = 1'b1;
            ST_FORMAT:
            begin
                cmd.fmt_write  = 1'b1;
                cmd.fmt_commit = stat.fmt_last;
            end
            ST_DONE:      cmd.out_load = !(out_valid_reg && out_stall);
            default:      cmd = '0;
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;

endmodule

/* design/bba_dpath.sv */
// Datapath of the bitmap block allocator: bitmap memory, scan, bit update,
// format sweep, free count and result registers. Depends on bba_pkg.
module bba_dpath
    import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  bba_cmd_t         cmd,
    input  logic [1:0]       command,
    input  logic [BLK_W-1:0] block_number,
    input  logic [CNT_W-1:0] total_blocks,
    input  logic [CNT_W-1:0] reserved_blocks,
    output bba_stat_t        stat,
    output logic [1:0]       status,
    output logic [BLK_W-1:0] result_block,
    output logic             bit_value,
    output logic [CNT_W-1:0] free_count
);

    // bitmap store, one word per entry, valid bit per word (unwritten reads as free)
    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [NWORDS-1:0]    vld_reg;

    bba_op_t              op_reg;
    logic [BLK_W-1:0]     blk_reg;
    logic [WADDR_W-1:0]   scan_addr_reg;
    logic [WADDR_W-1:0]   fmt_addr_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_vbit_reg;
    logic [WADDR_W-1:0]   rd_addr_reg;
    logic                 rd_pend_reg;
    logic                 found_reg;
    logic [BIT_W-1:0]     j_reg;
    logic [CNT_W-1:0]     free_reg, free_next;

    bba_status_t          res_status_reg, res_status_next;
    logic [BLK_W-1:0]     res_block_reg, res_block_next;
    logic                 res_bit_reg, res_bit_next;
    logic [CNT_W-1:0]     res_free_reg;

    logic [1:0]           out_status_reg;
    logic [BLK_W-1:0]     out_block_reg;
    logic                 out_bit_reg;
    logic [CNT_W-1:0]     out_free_reg;

    logic [CNT_W-1:0]     total_eff;
    logic [CNT_W-1:0]     rsv_eff;
    logic [WORD_BITS-1:0] word;
    logic [WADDR_W-1:0]   rd_addr;
    logic [BIT_W-1:0]     j_enc;
    logic [BLK_W-1:0]     n_cand;
    logic [WORD_BITS-1:0] blk_mask;
    logic                 blk_bit;
    logic                 blk_out_range;
    logic                 free_ok;
    logic [BLK_W-1:0]     fmt_base;
    logic [CNT_W:0]       fmt_diff;
    logic [WORD_BITS-1:0] fmt_word;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    assign total_eff = (total_blocks < MAX_CNT) ? total_blocks : MAX_CNT;
    assign rsv_eff   = (reserved_blocks < total_eff) ? reserved_blocks : total_eff;
    assign word      = rd_vbit_reg ? rd_data_reg : '0;
    assign rd_addr   = cmd.rd_blk ? blk_reg[BLK_W-1:BIT_W] : scan_addr_reg;

    assign stat.free_zero = (free_reg == '0);
    assign stat.hit       = rd_pend_reg && (word != ONES);
    assign stat.last      = rd_pend_reg && (rd_addr_reg == LAST_WORD);
    assign stat.fmt_last  = (fmt_addr_reg == LAST_WORD);

    // first clear bit, most significant first
    always_comb
    begin
        logic seen;
        seen  = 1'b0;
        j_enc = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!seen && !word[i])
            begin
                seen  = 1'b1;
                j_enc = BIT_W'(WORD_BITS - 1 - i);
            end
        end
    end

    assign n_cand        = {rd_addr_reg, j_enc};
    assign blk_mask      = TOP_BIT >> blk_reg[BIT_W-1:0];
    assign blk_bit       = |(word & blk_mask);
    assign blk_out_range = ({1'b0, blk_reg} >= total_eff);
    assign free_ok       = (op_reg == CMD_FREE) && !blk_out_range && blk_bit;

    // format word: leading ones for the reserved blocks that fall in this word
    assign fmt_base = {fmt_addr_reg, {BIT_W{1'b0}}};
    assign fmt_diff = {1'b0, rsv_eff} - {2'b0, fmt_base};
    always_comb
    begin
        if (fmt_diff[CNT_W] || (fmt_diff == '0))
            fmt_word = '0;
        else if (fmt_diff >= (CNT_W+1)'(WORD_BITS))
            fmt_word = ONES;
        else
            fmt_word = ~(ONES >> fmt_diff[BIT_W-1:0]);
    end

    // write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_addr_reg;
        wr_data = word;
        if (cmd.alloc_commit && found_reg)
        begin
            wr_en   = 1'b1;
            wr_data = word | (TOP_BIT >> j_reg);
        end
        else if (cmd.bit_commit && free_ok)
        begin
            wr_en   = 1'b1;
            wr_data = word & ~blk_mask;
        end
        else if (cmd.fmt_write)
        begin
            wr_en   = 1'b1;
            wr_addr = fmt_addr_reg;
            wr_data = fmt_word;
        end
    end

    // free count and result of the finishing step
    always_comb
    begin
        free_next       = free_reg;
        res_status_next = STAT_OK;
        res_block_next  = '0;
        res_bit_next    = 1'b0;
        if (cmd.alloc_commit)
        begin
            if (found_reg)
            begin
                free_next      = free_reg - CNT_W'(1);
                res_block_next = {rd_addr_reg, j_reg};
                res_bit_next   = 1'b1;
            end
            else
            begin
                res_status_next = STAT_NO_FREE;
            end
        end
        else if (cmd.bit_commit)
        begin
            res_block_next = blk_reg;
            if (blk_out_range)
                res_status_next = STAT_RANGE;
            else if (op_reg == CMD_TEST)
                res_bit_next = blk_bit;
            else if (!blk_bit)
                res_status_next = STAT_ALREADY_FREE;
            else if (free_reg != COUNT_MAX)
                free_next = free_reg + CNT_W'(1);
        end
        else if (cmd.fmt_commit)
        begin
            free_next = total_eff - rsv_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vbit_reg <= vld_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (cmd.load)
        begin
            op_reg  <= bba_op_t'(command);
            blk_reg <= block_number;
        end
        if (cmd.find_load)
            j_reg <= j_enc;
        if (cmd.alloc_commit || cmd.bit_commit || cmd.fmt_commit)
        begin
            res_status_reg <= res_status_next;
            res_block_reg  <= res_block_next;
            res_bit_reg    <= res_bit_next;
            res_free_reg   <= free_next;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_block_reg  <= res_block_reg;
            out_bit_reg    <= res_bit_reg;
            out_free_reg   <= res_free_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            scan_addr_reg <= '0;
            fmt_addr_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= '0;
        end
        else
        begin
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            rd_pend_reg <= cmd.rd_en;
            free_reg    <= free_next;
            if (cmd.load)
            begin
                scan_addr_reg <= '0;
                fmt_addr_reg  <= '0;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.rd_en && !cmd.rd_blk)
                    scan_addr_reg <= scan_addr_reg + WADDR_W'(1);
                if (cmd.fmt_write)
                    fmt_addr_reg <= fmt_addr_reg + WADDR_W'(1);
                if (cmd.find_load)
                    found_reg <= ({1'b0, n_cand} < total_eff);
            end
        end
    end

    assign status       = out_status_reg;
    assign result_block = out_block_reg;
    assign bit_value    = out_bit_reg;
    assign free_count   = out_free_reg;

endmodule

/* design/bitmap_block_allocator.sv */
// Top level of the bitmap block allocator: configuration registers and the
// sequencer/datapath pair. Depends on bba_pkg, bba_ctrl and bba_dpath.
//
//   channel   direction  handshake            payload
//   in        to block   in_valid / in_stall  command, block_number
//   out       from block out_valid / out_stall status, result_block, bit_value, free_count
//   config    to block   psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// Allocate reads one bitmap word per cycle, up to all 128 words, then does the
// bit search and write back; free and test read the one word that holds the block,
// and free writes it back; format writes one word per cycle over the whole bitmap.
// Reset clears the word valid bits, so the bitmap reads as all free at once; no
// clearing pass. The free count resets to zero and is set by format.
// A finished item waits in the output register while the next item is taken;
// an item only stalls at its end while that register is still occupied.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       command,
    input  logic [BLK_W-1:0] block_number,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       status,
    output logic [BLK_W-1:0] result_block,
    output logic             bit_value,
    output logic [CNT_W-1:0] free_count,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [CNT_W-1:0] total_blocks_reg;
    logic [CNT_W-1:0] reserved_blocks_reg;
    logic             cfg_wr;
    logic             cfg_idx;
    bba_cmd_t         cmd;
    bba_stat_t        stat;

    // Register index from the word address; byte lanes are ignored.
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_blocks_reg    <= MAX_CNT;
            reserved_blocks_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == CFG_TOTAL)
                total_blocks_reg <= pwdata[CNT_W-1:0];
            else
                reserved_blocks_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Readback, zero extended
    always_comb
    begin
        if (cfg_idx == CFG_TOTAL)
            prdata = {{(32-CNT_W){1'b0}}, total_blocks_reg};
        else
            prdata = {{(32-CNT_W){1'b0}}, reserved_blocks_reg};
    end

    // Sequencer: accepts an item only when idle, steps the datapath
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Datapath: bitmap memory, scan and update, free count, result registers
    bba_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .command         (command),
        .block_number    (block_number),
        .total_blocks    (total_blocks_reg),
        .reserved_blocks (reserved_blocks_reg),
        .stat            (stat),
        .status          (status),
        .result_block    (result_block),
        .bit_value       (bit_value),
        .free_count      (free_count)
    );

endmodule

/* design/bba_checker.sv */
// Port-level checks for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator.
module bba_checker
    import bba_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [1:0]       status,
    input logic [BLK_W-1:0] result_block,
    input logic             bit_value,
    input logic [CNT_W-1:0] free_count
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(result_block) && $stable(bit_value) && $stable(free_count))
        else $error("stalled result changed");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_no_free_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_NO_FREE) |-> (result_block == '0) && !bit_value)
        else $error("failed allocate reports a block");

    a_error_bit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == STAT_RANGE) || (status == STAT_ALREADY_FREE))
            |-> !bit_value)
        else $error("error result with used bit set");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (free_count <= MAX_CNT))
        else $error("free count above block total");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_block (result_block),
    .bit_value    (bit_value),
    .free_count   (free_count)
);

/* test/tb.sv */
// Self-checking testbench for bitmap_block_allocator: random and directed commands,
// a first-fit bitmap predictor in a small scoreboard class, and register writes over APB.
// Depends on bba_pkg and the bitmap_block_allocator RTL.
module tb;
    import bba_pkg::*;

    // One result item as the block presents it
    typedef struct {
        bba_status_t          status;
        logic [BLK_W-1:0]     blk;
        logic                 used;
        logic [CNT_W-1:0]     count;
    } alloc_result_t;

    // Predicts allocator results from its own copy of the bitmap and registers,
    // and holds the expected results until the block delivers them.
    class alloc_scoreboard;
        logic [WORD_BITS-1:0] used_map [NWORDS];
        logic [CNT_W-1:0]     free_blocks;
        logic [CNT_W-1:0]     total_reg;
        logic [CNT_W-1:0]     reserved_reg;
        logic [BLK_W-1:0]     last_alloc;
        alloc_result_t        expected_q [$];
        int                   errors;
        int                   checked;
        int                   items;
        int                   op_count [4];
        int                   refused;

        function new();
            foreach (used_map[w])
                used_map[w] = '0;
            free_blocks  = '0;
            total_reg    = MAX_CNT;
            reserved_reg = '0;
            last_alloc   = '0;
            errors       = 0;
            checked      = 0;
            items        = 0;
            refused      = 0;
            foreach (op_count[i])
                op_count[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [CNT_W-1:0] value);
            if (idx == CFG_TOTAL)
                total_reg = value;
            else
                reserved_reg = value;
        endfunction

        // Managed total: the register limited to the bitmap size
        function int eff_total();
            return (total_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_reg);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void mismatch(string msg);
            errors++;
            if (errors <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        // Apply one accepted command to the bitmap and queue its result
        function void note_item(bba_op_t op, logic [BLK_W-1:0] blk);
            alloc_result_t exp_r;
            int eff, n, w, j, r, b;
            bit hit;
            eff = eff_total();
            b = int'(blk);
            exp_r.status = STAT_OK;
            exp_r.blk    = '0;
            exp_r.used   = 1'b0;
            items++;
            op_count[op]++;
            case (op)
                CMD_ALLOC: begin
                    hit = 1'b0;
                    n = 0;
                    // Stop at the first word with a clear bit, even if that bit is past the total
                    if (free_blocks != 0)
                        for (w = 0; w < NWORDS && !hit; w++)
                            if (used_map[w] != ONES) begin
                                hit = 1'b1;
                                j = 0;
                                while (j < WORD_BITS && used_map[w][WORD_BITS-1-j])
                                    j++;
                                n = w * WORD_BITS + j;
                            end
                    if (hit && n < eff) begin
                        used_map[n / WORD_BITS][WORD_BITS-1-n%WORD_BITS] = 1'b1;
                        free_blocks = free_blocks - 1'b1;
                        exp_r.blk  = BLK_W'(n);
                        exp_r.used = 1'b1;
                        last_alloc = BLK_W'(n);
                    end
                    else begin
                        exp_r.status = STAT_NO_FREE;
                        refused++;
                    end
                end
                CMD_FREE, CMD_TEST: begin
                    exp_r.blk = blk;
                    if (b >= eff)
                        exp_r.status = STAT_RANGE;
                    else if (op == CMD_TEST)
                        exp_r.used = used_map[b / WORD_BITS][WORD_BITS-1-b%WORD_BITS];
                    else if (!used_map[b / WORD_BITS][WORD_BITS-1-b%WORD_BITS])
                        exp_r.status = STAT_ALREADY_FREE;
                    else begin
                        used_map[b / WORD_BITS][WORD_BITS-1-b%WORD_BITS] = 1'b0;
                        if (free_blocks != COUNT_MAX)
                            free_blocks = free_blocks + 1'b1;
                    end
                end
                default: begin
                    r = (int'(reserved_reg) < eff) ? int'(reserved_reg) : eff;
                    foreach (used_map[i])
                        used_map[i] = '0;
                    for (n = 0; n < r; n++)
                        used_map[n / WORD_BITS][WORD_BITS-1-n%WORD_BITS] = 1'b1;
                    free_blocks = CNT_W'(eff - r);
                end
            endcase
            exp_r.count = free_blocks;
            expected_q.push_back(exp_r);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp_r;
            if (expected_q.size() == 0) begin
                mismatch($sformatf("unexpected result st=%0d blk=%0d bit=%0d free=%0d",
                                   got.status, got.blk, got.used, got.count));
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            if (got.status !== exp_r.status || got.blk !== exp_r.blk ||
                got.used !== exp_r.used || got.count !== exp_r.count)
                mismatch($sformatf(
                    "result %0d: expected st=%0d blk=%0d bit=%0d free=%0d, got st=%0d blk=%0d bit=%0d free=%0d",
                    checked, exp_r.status, exp_r.blk, exp_r.used, exp_r.count,
                    got.status, got.blk, got.used, got.count));
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic [1:0]       command      = CMD_ALLOC;
    logic [BLK_W-1:0] block_number = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic [1:0]       status;
    logic [BLK_W-1:0] result_block;
    logic             bit_value;
    logic [CNT_W-1:0] free_count;
    logic             psel         = 1'b0;
    logic             penable      = 1'b0;
    logic             pwrite       = 1'b0;
    logic [2:0]       paddr        = '0;
    logic [31:0]      pwdata       = '0;
    logic [31:0]      prdata;
    logic             pready;

    alloc_scoreboard sb;

    bitmap_block_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_block (result_block),
        .bit_value    (bit_value),
        .free_count   (free_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the block hangs; far above the slowest legal run
    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: check every accepted item, then pick the next stall value.
    // The stall pattern cycles through four modes: never stall, stall now and then,
    // stall half the time, and long stall runs.
    bit [31:0]   rx_cycle = '0;
    int unsigned rx_hold  = 0;

    always @(posedge clk)
    begin
        alloc_result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.status = bba_status_t'(status);
            got.blk    = result_block;
            got.used   = bit_value;
            got.count  = free_count;
            sb.check_result(got);
        end
        rx_cycle++;
        if (rx_hold != 0) begin
            rx_hold--;
            out_stall <= 1'b1;
        end
        else begin
            case (rx_cycle[9:8])
                2'd0: out_stall <= 1'b0;
                2'd1: out_stall <= ($urandom_range(0, 7) == 0);
                2'd2: out_stall <= $urandom_range(0, 1);
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        rx_hold = $urandom_range(1, 15);
                        out_stall <= 1'b1;
                    end
                    else
                        out_stall <= 1'b0;
                end
            endcase
        end
    end

    // Present one item and hold it until the block takes it; call at a rising edge
    task automatic push_command(bba_op_t op, logic [BLK_W-1:0] blk);
        in_valid     <= 1'b1;
        command      <= op;
        block_number <= blk;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(op, blk);
    endtask

    // Drop valid and wait until every expected item has come back
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write, then read back the same register
    task automatic write_reg(logic idx, logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== 32'(value))
            sb.mismatch($sformatf("register %0d read back %0h, wrote %0h", idx, prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Drain the block, then set the managed total and the reserved count
    task automatic set_geometry(int total, int reserved);
        wait_quiet();
        write_reg(CFG_TOTAL, CNT_W'(total));
        write_reg(CFG_RESERVED, CNT_W'(reserved));
        @(posedge clk);
    endtask

    initial
    begin
        int          phase, k, t, rsv, pick, gap;
        int unsigned burst_left;
        bit          pause;
        bba_op_t     op;
        logic [BLK_W-1:0] blk;

        sb = new();
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: after reset the count is zero, so allocate refuses
        push_command(CMD_ALLOC, 12'd0);
        push_command(CMD_FREE, 12'd0);
        push_command(CMD_FORMAT, 12'hFFF);
        push_command(CMD_ALLOC, 12'hFFF);
        push_command(CMD_ALLOC, 12'd0);
        push_command(CMD_FREE, 12'd1);
        push_command(CMD_FREE, 12'd1);
        push_command(CMD_TEST, 12'd0);
        push_command(CMD_TEST, 12'hFFF);

        // Small disk nearly all reserved: run it dry, then poke past the end
        set_geometry(40, 38);
        push_command(CMD_FORMAT, 12'd0);
        push_command(CMD_ALLOC, 12'd0);
        push_command(CMD_ALLOC, 12'd0);
        push_command(CMD_ALLOC, 12'd0);
        push_command(CMD_FREE, 12'd39);
        push_command(CMD_FREE, 12'd40);

        // Shrink the total below the first clear bit; reserved exceeds total
        set_geometry(3, 38);
        push_command(CMD_ALLOC, 12'd0);
        push_command(CMD_FORMAT, 12'd0);

        // Zero total: everything is out of range
        set_geometry(0, 0);
        push_command(CMD_TEST, 12'd0);
        push_command(CMD_FREE, 12'hFFF);
        push_command(CMD_FORMAT, 12'd0);

        // Oversized registers: whole bitmap reserved, then free and retake the last block
        set_geometry(8191, 8191);
        push_command(CMD_FORMAT, 12'd0);
        push_command(CMD_ALLOC, 12'd0);
        push_command(CMD_FREE, 12'hFFF);
        push_command(CMD_ALLOC, 12'd0);

        // Random phases, each opened by a format under a fresh geometry
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin t = 4096; rsv = 0; end
                1: begin t = $urandom_range(1, 64); rsv = $urandom_range(0, t + 4); end
                2: begin t = 4096; rsv = $urandom_range(3900, 4090); end
                3: begin t = 8191; rsv = 8191; end
                4: begin t = $urandom_range(1, 4096); rsv = $urandom_range(0, t); end
                5: begin t = 1; rsv = 0; end
                6: begin t = $urandom_range(4097, 8191); rsv = $urandom_range(0, 200); end
                default: begin t = $urandom_range(65, 512); rsv = 0; end
            endcase
            set_geometry(t, rsv);
            push_command(CMD_FORMAT, 12'($urandom));
            for (k = 0; k < 124; k++) begin
                // Bursts of items with random gaps; now and then hold off until drained
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    pause = ($urandom_range(0, 24) == 0);
                    if (gap != 0 || pause) begin
                        in_valid <= 1'b0;
                        if (gap == 0)
                            gap = 1;
                        repeat (gap) @(posedge clk);
                        if (pause)
                            while (sb.pending() != 0)
                                @(posedge clk);
                    end
                end
                burst_left--;

                pick = $urandom_range(0, 99);
                if (pick < 45)
                    op = CMD_ALLOC;
                else if (pick < 72)
                    op = CMD_FREE;
                else if (pick < 96)
                    op = CMD_TEST;
                else
                    op = CMD_FORMAT;

                // Aim frees and tests mostly at recently allocated blocks and the end of the disk
                case ($urandom_range(0, 3))
                    0:       blk = 12'($urandom);
                    1, 2:    blk = sb.last_alloc - 12'($urandom_range(0, 15));
                    default: blk = 12'(sb.eff_total() - 1 + $urandom_range(0, 1));
                endcase
                push_command(op, blk);
            end
        end

        wait_quiet();
        // Allow for any stray result trailing behind the last one
        repeat (150) @(posedge clk);

        $display("Covered %0d items: %0d allocate (%0d refused), %0d free, %0d test, %0d format",
                 sb.items, sb.op_count[CMD_ALLOC], sb.refused, sb.op_count[CMD_FREE],
                 sb.op_count[CMD_TEST], sb.op_count[CMD_FORMAT]);
        $display("Checked %0d results over 13 geometries, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/bba_pkg.sv
design/bba_ctrl.sv
design/bba_dpath.sv
design/bitmap_block_allocator.sv
design/bba_checker.sv
test/tb.sv
